// ===== rtl/core/ip_address_text_validator_assert.svh =====
// assertion macros shared by the validator modules
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

// checked outside reset
`define IPV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IPV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ipv_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv_pkg
// shared types and constants of the address text validator
// ----------------------------------------------------------------------------
package ipv_pkg;

  localparam logic [1:0] CLASS_V4   = 2'd0;
  localparam logic [1:0] CLASS_V6   = 2'd1;
  localparam logic [1:0] CLASS_NONE = 2'd2;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam int V4_VAL_W = 10;
  localparam int V4_PRD_W = 12;
  localparam int V4_CNT_W = 3;
  localparam int V4_GRP_W = 3;
  localparam int V6_CNT_W = 3;
  localparam int V6_GRP_W = 4;

  localparam logic [V4_VAL_W-1:0] V4_VAL_MAX = 10'd255;
  localparam logic [V4_VAL_W-1:0] V4_VAL_SAT = 10'd256;
  localparam logic [V4_CNT_W-1:0] V4_DIG_MAX = 3'd3;
  localparam logic [V4_CNT_W-1:0] V4_DIG_SAT = 3'd4;
  localparam logic [V4_GRP_W-1:0] V4_GRP_MAX = 3'd3;
  localparam logic [V4_GRP_W-1:0] V4_GRP_SAT = 3'd4;
  localparam logic [V6_CNT_W-1:0] V6_DIG_MAX = 3'd4;
  localparam logic [V6_CNT_W-1:0] V6_DIG_SAT = 3'd5;
  localparam logic [V6_GRP_W-1:0] V6_GRP_MAX = 4'd7;
  localparam logic [V6_GRP_W-1:0] V6_GRP_SAT = 4'd8;

  // queue between classifier and state update
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       is_digit;
    logic       is_hex;
    logic       is_dot;
    logic       is_colon;
    logic [3:0] digit;
    logic       last;
  } chr_t;

  typedef struct packed {
    logic valid;
    chr_t data;
  } q_push_t;

  typedef struct packed {
    logic valid;
    chr_t data;
  } q_head_t;

endpackage

// ===== rtl/core/ipv_in_if.sv =====
// ----------------------------------------------------------------------------
// ipv_in_if
// character channel: one text byte and an end-of-string flag per item
// ----------------------------------------------------------------------------
interface ipv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

// ===== rtl/core/ipv_out_if.sv =====
// ----------------------------------------------------------------------------
// ipv_out_if
// result channel: one address class per item
// ----------------------------------------------------------------------------
interface ipv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr_class;

  modport source (output valid, output addr_class, input ready);
  modport sink   (input valid, input addr_class, output ready);
endinterface

// ===== rtl/core/ipv_front.sv =====
// ----------------------------------------------------------------------------
// ipv_front
// accepts characters and sorts each into digit, hex, dot, colon or other
// ----------------------------------------------------------------------------
module ipv_front (
  ipv_in_if.sink          in_if,
  input  logic            q_ready,
  output ipv_pkg::q_push_t push
);

  logic [7:0] c;

  assign c           = in_if.char_in;
  assign in_if.ready = q_ready;

  always_comb begin
    push.valid         = in_if.valid;
    push.data.is_digit = (c >= ipv_pkg::CH_0) && (c <= ipv_pkg::CH_9);
    push.data.is_hex   = push.data.is_digit ||
                         ((c >= ipv_pkg::CH_LA) && (c <= ipv_pkg::CH_LF)) ||
                         ((c >= ipv_pkg::CH_UA) && (c <= ipv_pkg::CH_UF));
    push.data.is_dot   = (c == ipv_pkg::CH_DOT);
    push.data.is_colon = (c == ipv_pkg::CH_COLON);
    push.data.digit    = 4'(c - ipv_pkg::CH_0);
    push.data.last     = in_if.last;
  end

endmodule

// ===== rtl/core/ipv_queue.sv =====
// ----------------------------------------------------------------------------
// ipv_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_assert.svh"

module ipv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ipv_pkg::q_push_t push,
  output logic             q_ready,
  input  logic             pop,
  output ipv_pkg::q_head_t head
);

  ipv_pkg::chr_t                  mem_r [ipv_pkg::QDEPTH];
  logic [ipv_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ipv_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ipv_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;

  assign q_ready    = (count_r != ipv_pkg::QCNT_W'(ipv_pkg::QDEPTH));
  assign do_push    = push.valid && q_ready;
  assign head.valid = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ipv_pkg::QPTR_W'(ipv_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ipv_pkg::QPTR_W'(ipv_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  `IPV_ASSERT(a_pop_nonempty, pop |-> head.valid, "pop from empty queue")
  `IPV_ASSERT(a_count_bound, count_r <= ipv_pkg::QCNT_W'(ipv_pkg::QDEPTH), "queue count overflow")
  `IPV_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> count_r == '0, "queue not empty after reset")

endmodule

// ===== rtl/core/ipv_back.sv =====
// ----------------------------------------------------------------------------
// ipv_back
// per-string ipv4 and ipv6 state update and the registered class result
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_assert.svh"

module ipv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ipv_pkg::q_head_t head,
  output logic             pop,
  ipv_out_if.source        out_if
);

  logic                           v4_ok_r, v4_ok_nxt;
  logic                           v6_ok_r, v6_ok_nxt;
  logic                           seen_dot_r, seen_dot_nxt;
  logic                           seen_colon_r, seen_colon_nxt;
  logic [ipv_pkg::V4_GRP_W-1:0]   v4_grp_r, v4_grp_nxt;
  logic [ipv_pkg::V4_CNT_W-1:0]   v4_cnt_r, v4_cnt_nxt;
  logic [ipv_pkg::V4_VAL_W-1:0]   v4_val_r, v4_val_nxt;
  logic                           v4_lead_r, v4_lead_nxt;
  logic [ipv_pkg::V6_GRP_W-1:0]   v6_grp_r, v6_grp_nxt;
  logic [ipv_pkg::V6_CNT_W-1:0]   v6_cnt_r, v6_cnt_nxt;
  logic [ipv_pkg::V4_PRD_W-1:0]   v4_prod;
  logic [1:0]                     cls;
  logic                           out_valid_r;
  logic [1:0]                     out_class_r;
  ipv_pkg::chr_t                  ch;

  assign ch  = head.data;
  assign pop = head.valid && (!ch.last || !out_valid_r || out_if.ready);

  assign out_if.valid      = out_valid_r;
  assign out_if.addr_class = out_class_r;

  // value times ten plus digit
  assign v4_prod = (ipv_pkg::V4_PRD_W'(v4_val_r) << 3) + (ipv_pkg::V4_PRD_W'(v4_val_r) << 1) +
                   ipv_pkg::V4_PRD_W'(ch.digit);

  always_comb begin
    v4_ok_nxt      = v4_ok_r;
    v6_ok_nxt      = v6_ok_r;
    seen_dot_nxt   = seen_dot_r || ch.is_dot;
    seen_colon_nxt = seen_colon_r || ch.is_colon;
    v4_grp_nxt     = v4_grp_r;
    v4_cnt_nxt     = v4_cnt_r;
    v4_val_nxt     = v4_val_r;
    v4_lead_nxt    = v4_lead_r;
    v6_grp_nxt     = v6_grp_r;
    v6_cnt_nxt     = v6_cnt_r;

    if (ch.is_digit) begin
      if (v4_cnt_r == '0) begin
        v4_lead_nxt = (ch.digit == 4'd0);
      end else if (v4_lead_r) begin
        v4_ok_nxt = 1'b0;
      end
      if (v4_cnt_r < ipv_pkg::V4_DIG_SAT) begin
        v4_cnt_nxt = v4_cnt_r + 1'b1;
      end
      if (v4_cnt_nxt > ipv_pkg::V4_DIG_MAX) begin
        v4_ok_nxt = 1'b0;
      end
      if (v4_prod > ipv_pkg::V4_PRD_W'(ipv_pkg::V4_VAL_MAX)) begin
        v4_ok_nxt  = 1'b0;
        v4_val_nxt = ipv_pkg::V4_VAL_SAT;
      end else begin
        v4_val_nxt = v4_prod[ipv_pkg::V4_VAL_W-1:0];
      end
    end else if (ch.is_dot) begin
      if (v4_cnt_r == '0) begin
        v4_ok_nxt = 1'b0;
      end
      if (v4_grp_r < ipv_pkg::V4_GRP_SAT) begin
        v4_grp_nxt = v4_grp_r + 1'b1;
      end
      if (v4_grp_nxt > ipv_pkg::V4_GRP_MAX) begin
        v4_ok_nxt = 1'b0;
      end
      v4_cnt_nxt  = '0;
      v4_val_nxt  = '0;
      v4_lead_nxt = 1'b0;
    end else begin
      v4_ok_nxt = 1'b0;
    end

    if (ch.is_hex) begin
      if (v6_cnt_r < ipv_pkg::V6_DIG_SAT) begin
        v6_cnt_nxt = v6_cnt_r + 1'b1;
      end
      if (v6_cnt_nxt > ipv_pkg::V6_DIG_MAX) begin
        v6_ok_nxt = 1'b0;
      end
    end else if (ch.is_colon) begin
      if (v6_cnt_r == '0) begin
        v6_ok_nxt = 1'b0;
      end
      if (v6_grp_r < ipv_pkg::V6_GRP_SAT) begin
        v6_grp_nxt = v6_grp_r + 1'b1;
      end
      if (v6_grp_nxt > ipv_pkg::V6_GRP_MAX) begin
        v6_ok_nxt = 1'b0;
      end
      v6_cnt_nxt = '0;
    end else begin
      v6_ok_nxt = 1'b0;
    end

    priority if (seen_dot_nxt) begin
      cls = (v4_ok_nxt && (v4_cnt_nxt != '0) && (v4_grp_nxt == ipv_pkg::V4_GRP_MAX)) ?
            ipv_pkg::CLASS_V4 : ipv_pkg::CLASS_NONE;
    end else if (seen_colon_nxt) begin
      cls = (v6_ok_nxt && (v6_cnt_nxt != '0) && (v6_grp_nxt == ipv_pkg::V6_GRP_MAX)) ?
            ipv_pkg::CLASS_V6 : ipv_pkg::CLASS_NONE;
    end else begin
      cls = ipv_pkg::CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (pop && ch.last)) begin
      v4_ok_r      <= 1'b1;
      v6_ok_r      <= 1'b1;
      seen_dot_r   <= 1'b0;
      seen_colon_r <= 1'b0;
      v4_grp_r     <= '0;
      v4_cnt_r     <= '0;
      v4_val_r     <= '0;
      v4_lead_r    <= 1'b0;
      v6_grp_r     <= '0;
      v6_cnt_r     <= '0;
    end else if (pop) begin
      v4_ok_r      <= v4_ok_nxt;
      v6_ok_r      <= v6_ok_nxt;
      seen_dot_r   <= seen_dot_nxt;
      seen_colon_r <= seen_colon_nxt;
      v4_grp_r     <= v4_grp_nxt;
      v4_cnt_r     <= v4_cnt_nxt;
      v4_val_r     <= v4_val_nxt;
      v4_lead_r    <= v4_lead_nxt;
      v6_grp_r     <= v6_grp_nxt;
      v6_cnt_r     <= v6_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && ch.last) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ch.last) begin
      out_class_r <= cls;
    end
  end

  `IPV_ASSERT(a_last_gives_result, pop && ch.last |=> out_valid_r, "no result after last item")
  `IPV_ASSERT(a_clear_after_last, pop && ch.last |=> v4_ok_r && v6_ok_r && !seen_dot_r && !seen_colon_r && v4_cnt_r == '0 && v6_grp_r == '0, "state not cleared after last item")
  `IPV_ASSERT(a_v4_saturation, v4_val_r <= ipv_pkg::V4_VAL_SAT && v4_cnt_r <= ipv_pkg::V4_DIG_SAT, "ipv4 group tracking past saturation")
  `IPV_ASSERT(a_no_overwrite, out_valid_r && !out_if.ready |-> !(pop && ch.last), "pending result overwritten")

endmodule

// ===== rtl/core/ip_address_text_validator.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_validator
// Takes address text one character per item, last set on the final one, and
// returns one class per string: 0 IPv4, 1 IPv6, 2 neither. It sustains one
// character per cycle; the figure is set by the state update in the back
// end, which applies one queued character each clock. Characters pass
// through a two-entry queue, and the class is loaded into the output
// register when the last character is popped from it. While a result waits
// to be taken, characters of the next string keep flowing; only that
// string's last character waits for the result register to free up.
// ----------------------------------------------------------------------------
module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  ipv_in_if.sink     in_if,
  ipv_out_if.source  out_if
);

  ipv_pkg::q_push_t push;
  ipv_pkg::q_head_t head;
  logic             q_ready;
  logic             pop;

  ipv_front u_front (
    .in_if   (in_if),
    .q_ready (q_ready),
    .push    (push)
  );

  ipv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .pop     (pop),
    .head    (head)
  );

  ipv_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
